### rtl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and codes of the sorted term table
// Term word layout, compare-unit result, operation and status codes, states.
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef struct packed {
    logic [15:0]        order;
    logic signed [31:0] coef;
  } term_t;

  typedef struct packed {
    logic               lt;
    logic               eq;
    logic signed [31:0] sum;
  } cmp_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NEGATIVE = 3'd2,
    ST_BEYOND   = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_SHIFT,
    S_REM_SCAN,
    S_REM_SHIFT,
    S_GET_RD,
    S_RESP
  } state_t;

endpackage

### rtl/stt_if.sv
// ----------------------------------------------------------------------------
// stt_if: valid/ready channels of the sorted term table
// Request channel (op, order, value, position) and result channel.
// ----------------------------------------------------------------------------
interface stt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [15:0]        term_order;
  logic signed [31:0] term_value;
  logic signed [6:0]  position;

  modport source (output valid, output op, output term_order, output term_value,
                  output position, input ready);
  modport sink   (input valid, input op, input term_order, input term_value,
                  input position, output ready);
endinterface

interface stt_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [15:0]        found_order;
  logic signed [31:0] found_coef;

  modport source (output valid, output status, output found_order, output found_coef,
                  input ready);
  modport sink   (input valid, input status, input found_order, input found_coef,
                  output ready);
endinterface

### rtl/stt_mem.sv
// ----------------------------------------------------------------------------
// stt_mem: term storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stt_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output stt_pkg::term_t  rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  stt_pkg::term_t  wr_data
);
  import stt_pkg::*;

  term_t mem [DEPTH];
  term_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/stt_alu.sv
// ----------------------------------------------------------------------------
// stt_alu: shared compare and accumulate unit
// Compares a stored order with the key and adds the key value to its coef.
// ----------------------------------------------------------------------------
module stt_alu (
  input  stt_pkg::term_t      entry,
  input  logic [15:0]         key_order,
  input  logic signed [31:0]  key_value,
  output stt_pkg::cmp_t       res
);
  import stt_pkg::*;

  always_comb begin
    res.lt  = entry.order < key_order;
    res.eq  = entry.order == key_order;
    res.sum = entry.coef + key_value;   // wraps at 32 bits
  end

endmodule

### rtl/sorted_term_table.sv
// One item at a time: the next word is taken in the cycle after the result word
//   is loaded. Insert and remove scan the term memory, one entry read per cycle; get
//   errors, remove on an empty table, first insert and the unused selector read no slot.
// Reset (rst_n low, synchronous): table empty, no result pending; memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_term_table: sorted table of polynomial terms
// Keeps (order, coefficient) terms in ascending order in a memory with one read
// and one write port. A small sequencer walks the memory from slot 0 through
// the shared compare unit: insert accumulates or ripples the tail up by one
// slot, remove ripples the tail down by one slot, get reads one slot.
// ----------------------------------------------------------------------------
module sorted_term_table #(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  stt_in_if.sink     in_ch,
  stt_out_if.source  out_ch
);
  import stt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);       // count 0..DEPTH
  localparam int AW = $clog2(DEPTH);           // slot address
  localparam int WW = (CW > 7) ? CW : 7;       // width for position compare
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  // sequencer state
  state_t             state_r, state_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  term_t              carry_r, carry_nxt;      // word displaced during insert ripple
  logic [15:0]        key_order_r;
  logic signed [31:0] key_value_r;

  // result staging
  status_t            res_status_r, res_status_nxt;
  logic [15:0]        res_order_r, res_order_nxt;
  logic signed [31:0] res_coef_r, res_coef_nxt;

  // output register
  logic               out_valid_r;
  status_t            out_status_r;
  logic [15:0]        out_order_r;
  logic signed [31:0] out_coef_r;

  // memory and compare unit hookup
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  term_t              rd_data, wr_data;
  cmp_t               cmp;

  logic               in_ready;
  logic               out_free;
  logic               empty, full, last;
  logic [CW-1:0]      idx_inc, idx_dec;
  logic [WW-1:0]      pos_ext, count_ext;
  term_t              new_term;

  stt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  stt_alu u_alu (
    .entry     (rd_data),
    .key_order (key_order_r),
    .key_value (key_value_r),
    .res       (cmp)
  );

  assign empty     = count_r == '0;
  assign full      = count_r == DEPTH_C;
  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign last      = idx_inc == count_r;     // current slot is the top term
  assign pos_ext   = WW'(in_ch.position[5:0]);
  assign count_ext = WW'(count_r);
  assign new_term  = '{order: key_order_r, coef: key_value_r};
  assign out_free  = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    carry_r      <= carry_nxt;
    res_status_r <= res_status_nxt;
    res_order_r  <= res_order_nxt;
    res_coef_r   <= res_coef_nxt;
    if (in_ready && in_ch.valid) begin
      key_order_r <= in_ch.term_order;
      key_value_r <= in_ch.term_value;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    carry_nxt      = carry_r;
    res_status_nxt = res_status_r;
    res_order_nxt  = res_order_r;
    res_coef_nxt   = res_coef_r;
    rd_en          = 1'b0;
    rd_addr        = idx_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = idx_r[AW-1:0];
    wr_data        = carry_r;
    in_ready       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) begin
          res_status_nxt = ST_OK;
          res_order_nxt  = '0;
          res_coef_nxt   = '0;
          idx_nxt        = '0;
          state_nxt      = S_RESP;
          unique case (in_ch.op)
            OP_INSERT: begin
              if (empty) begin
                // first term goes straight into slot 0
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = '{order: in_ch.term_order, coef: in_ch.term_value};
                count_nxt = CW'(1);
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_INS_SCAN;
              end
            end
            OP_REMOVE: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_REM_SCAN;
              end
            end
            OP_GET: begin
              priority if (empty) begin
                res_status_nxt = ST_EMPTY;
              end else if (in_ch.position[6]) begin
                res_status_nxt = ST_NEGATIVE;
              end else if (pos_ext >= count_ext) begin
                res_status_nxt = ST_BEYOND;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = pos_ext[AW-1:0];
                state_nxt = S_GET_RD;
              end
            end
            default: begin
              // unused selector: answer ok, touch nothing
            end
          endcase
        end
      end

      S_INS_SCAN: begin
        priority if (cmp.eq) begin
          // accumulate into the matching term; a zero sum stays in the table
          wr_en     = 1'b1;
          wr_data   = '{order: rd_data.order, coef: cmp.sum};
          state_nxt = S_RESP;
        end else if (cmp.lt) begin
          if (last) begin
            if (full) begin
              res_status_nxt = ST_FULL;
            end else begin
              // append above every stored term
              wr_en     = 1'b1;
              wr_addr   = count_r[AW-1:0];
              wr_data   = new_term;
              count_nxt = count_r + CW'(1);
            end
            state_nxt = S_RESP;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[AW-1:0];
            idx_nxt = idx_inc;
          end
        end else begin
          if (full) begin
            res_status_nxt = ST_FULL;
            state_nxt      = S_RESP;
          end else begin
            // place the new term here, ripple the old one up
            wr_en     = 1'b1;
            wr_data   = new_term;
            carry_nxt = rd_data;
            idx_nxt   = idx_inc;
            if (!last) begin
              rd_en   = 1'b1;
              rd_addr = idx_inc[AW-1:0];
            end
            state_nxt = S_INS_SHIFT;
          end
        end
      end

      S_INS_SHIFT: begin
        wr_en   = 1'b1;
        wr_data = carry_r;
        if (idx_r == count_r) begin
          count_nxt = count_r + CW'(1);
          state_nxt = S_RESP;
        end else begin
          carry_nxt = rd_data;
          idx_nxt   = idx_inc;
          if (!last) begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[AW-1:0];
          end
        end
      end

      S_REM_SCAN: begin
        priority if (cmp.lt) begin
          if (last) begin
            state_nxt = S_RESP;          // no match, table unchanged
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_inc[AW-1:0];
            idx_nxt = idx_inc;
          end
        end else if (cmp.eq) begin
          if (last) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_RESP;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = idx_inc[AW-1:0];
            idx_nxt   = idx_inc;
            state_nxt = S_REM_SHIFT;
          end
        end else begin
          state_nxt = S_RESP;            // passed the key, no match
        end
      end

      S_REM_SHIFT: begin
        // drop each upper term one slot down over the removed one
        wr_en   = 1'b1;
        wr_addr = idx_dec[AW-1:0];
        wr_data = rd_data;
        if (last) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[AW-1:0];
          idx_nxt = idx_inc;
        end
      end

      S_GET_RD: begin
        res_order_nxt = rd_data.order;
        res_coef_nxt  = rd_data.coef;
        state_nxt     = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result word register: load from staging, hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RESP && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && out_free) begin
      out_status_r <= res_status_r;
      out_order_r  <= res_order_r;
      out_coef_r   <= res_coef_r;
    end
  end

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_order = out_order_r;
  assign out_ch.found_coef  = out_coef_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("term count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1) || count_r == $past(count_r) - CW'(1)))
    else $error("term count moved by more than one");

  a_wr_addr: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CW'(wr_addr) < DEPTH_C))
    else $error("memory write beyond depth");

  a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r == S_IDLE) |-> (in_ch.valid && empty))
    else $error("memory write while idle");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_order_r == '0 && out_coef_r == '0))
    else $error("error result carries term data");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted term table
// Drives insert, remove, get and unused-selector words through the request
// channel, keeps a shadow copy of the sorted term table to predict each result
// word, and checks every result field against the oldest prediction while
// both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import stt_pkg::*;

  localparam int          DEPTH          = 16;
  localparam int          CLK_PERIOD     = 12;
  localparam int          RANDOM_WORDS   = 1500;
  localparam int          HOLDOFF_CYCLES = 400;
  localparam int          CYCLE_LIMIT    = 1_000_000;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  // One predicted result word.
  typedef struct packed {
    status_t            status;
    logic [15:0]        order;
    logic signed [31:0] coef;
  } reply_t;

  logic clk;
  logic rst_n;

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  sorted_term_table #(
    .DEPTH (DEPTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the table: ascending orders in slots below shadow_count.
  logic [15:0]        shadow_orders [DEPTH];
  logic signed [31:0] shadow_coefs  [DEPTH];
  int                 shadow_count;

  // Predicted result words, oldest first.
  reply_t awaited_replies [$];
  reply_t next_reply;

  int unsigned error_count;
  int unsigned cycle_count;

  // Traffic shaping knobs, flipped by the tests.
  bit sender_gaps_on;
  bit receiver_stalls_on;
  bit holdoff_req;
  int stall_left;

  // --------------------------------------------------------------------------
  // Clock and cycle watchdog
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: apply one accepted word to the shadow table and return the
  // result word it must produce.
  // --------------------------------------------------------------------------
  function automatic reply_t apply_table_op(logic [1:0] op, logic [15:0] ord,
                                            logic signed [31:0] val,
                                            logic signed [6:0] pos);
    reply_t r;
    int     slot;
    int     k;
    r.status = ST_OK;
    r.order  = '0;
    r.coef   = '0;
    slot     = 0;
    case (op)
      OP_INSERT: begin
        // Walk to the first slot whose order is not below ord.
        while (slot < shadow_count && shadow_orders[slot] < ord) slot++;
        if (slot < shadow_count && shadow_orders[slot] == ord) begin
          // Accumulate with wraparound; a zero coefficient keeps its term.
          shadow_coefs[slot] = shadow_coefs[slot] + val;
        end else if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // Ripple the tail up by one slot and drop the new term in.
          for (k = shadow_count; k > slot; k--) begin
            shadow_orders[k] = shadow_orders[k - 1];
            shadow_coefs[k]  = shadow_coefs[k - 1];
          end
          shadow_orders[slot] = ord;
          shadow_coefs[slot]  = val;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          while (slot < shadow_count && shadow_orders[slot] < ord) slot++;
          // No match leaves the table alone and still reports ok.
          if (slot < shadow_count && shadow_orders[slot] == ord) begin
            for (k = slot; k + 1 < shadow_count; k++) begin
              shadow_orders[k] = shadow_orders[k + 1];
              shadow_coefs[k]  = shadow_coefs[k + 1];
            end
            shadow_count--;
          end
        end
      end
      OP_GET: begin
        // Empty wins over a negative index, which wins over beyond-end.
        if (shadow_count == 0) r.status = ST_EMPTY;
        else if (pos < 0) r.status = ST_NEGATIVE;
        else if (int'(pos) >= shadow_count) r.status = ST_BEYOND;
        else begin
          r.order = shadow_orders[pos];
          r.coef  = shadow_coefs[pos];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int gap_cycles(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: offer one word at a falling edge, hold it until the rising edge
  // that takes it, predict its result, then idle for a random gap. Valid is
  // left high when no gap follows so the next word goes out back to back.
  // --------------------------------------------------------------------------
  task automatic send_word(logic [1:0] op, logic [15:0] ord,
                           logic signed [31:0] val, logic signed [6:0] pos);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.term_order <= ord;
    in_ch.term_value <= val;
    in_ch.position   <= pos;
    do @(posedge clk); while (!in_ch.ready);
    awaited_replies.push_back(apply_table_op(op, ord, val, pos));
    @(negedge clk);
    gap = gap_cycles(sender_gaps_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request, counted here.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (holdoff_req) begin
      holdoff_req = 1'b0;
      stall_left  = HOLDOFF_CYCLES;
    end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
      stall_left = gap_cycles(receiver_stalls_on);
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left   = stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Checker: compare every taken result word with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result word: status %0d order %0d coef %0d",
                 $time, out_ch.status, out_ch.found_order, out_ch.found_coef);
        error_count++;
      end else begin
        next_reply = awaited_replies.pop_front();
        if (out_ch.status !== next_reply.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, next_reply.status, out_ch.status);
          error_count++;
        end
        if (out_ch.found_order !== next_reply.order) begin
          $display("%0t: found_order mismatch: expected %0d, actual %0d",
                   $time, next_reply.order, out_ch.found_order);
          error_count++;
        end
        if (out_ch.found_coef !== next_reply.coef) begin
          $display("%0t: found_coef mismatch: expected %0d, actual %0d",
                   $time, next_reply.coef, out_ch.found_coef);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Get and remove on a table that reset left empty.
  task automatic test_empty_table();
    send_word(OP_GET, 16'd0, 32'sd0, -7'sd1);
    send_word(OP_GET, 16'd0, 32'sd0, 7'sd0);
    send_word(OP_REMOVE, 16'd0, 32'sd0, 7'sd0);
  endtask

  // Extreme orders land in sorted place; accumulate wraps and keeps zeros.
  task automatic test_sorted_insert();
    send_word(OP_INSERT, 16'hFFFF, 32'sh7FFF_FFFF, 7'sd0);
    send_word(OP_INSERT, 16'h0000, 32'sh8000_0000, 7'sd0);
    send_word(OP_INSERT, 16'd300, 32'sd5, 7'sd0);
    send_word(OP_INSERT, 16'd300, -32'sd5, 7'sd0);
    send_word(OP_INSERT, 16'hFFFF, 32'sd1, 7'sd0);
    send_word(OP_INSERT, 16'h0000, -32'sd1, 7'sd0);
  endtask

  // Every index class against a three-term table.
  task automatic test_get_positions();
    send_word(OP_GET, 16'd0, 32'sd0, 7'sd0);
    send_word(OP_GET, 16'd0, 32'sd0, 7'sd1);
    send_word(OP_GET, 16'd0, 32'sd0, 7'sd2);
    send_word(OP_GET, 16'd0, 32'sd0, 7'sd3);
    send_word(OP_GET, 16'd0, 32'sd0, 7'sd63);
    send_word(OP_GET, 16'd0, 32'sd0, -7'sd64);
    send_word(OP_GET, 16'd0, 32'sd0, -7'sd1);
  endtask

  // Head removal, a miss, tail removal, then empty the table and remove again.
  task automatic test_remove_cases();
    send_word(OP_REMOVE, 16'h0000, 32'sd0, 7'sd0);
    send_word(OP_REMOVE, 16'd1234, 32'sd0, 7'sd0);
    send_word(OP_REMOVE, 16'hFFFF, 32'sd0, 7'sd0);
    send_word(OP_GET, 16'd0, 32'sd0, 7'sd0);
    send_word(OP_REMOVE, 16'd300, 32'sd0, 7'sd0);
    send_word(OP_REMOVE, 16'd300, 32'sd0, 7'sd0);
  endtask

  // The spare selector with every payload bit set must leave the table alone.
  task automatic test_unused_op();
    send_word(OP_INSERT, 16'd42, 32'sd9, 7'sd0);
    send_word(OP_UNUSED, 16'hFFFF, -32'sd1, -7'sd1);
    send_word(OP_GET, 16'd0, 32'sd0, 7'sd0);
  endtask

  // Fill to DEPTH, reject a new order, still accumulate, then drain.
  task automatic test_full_table();
    logic [15:0] ord;
    bit          present;
    int          k;
    while (shadow_count < DEPTH) send_word(OP_INSERT, 16'($urandom), $urandom, 7'sd0);
    do begin
      ord     = 16'($urandom);
      present = 1'b0;
      for (k = 0; k < shadow_count; k++) if (shadow_orders[k] == ord) present = 1'b1;
    end while (present);
    send_word(OP_INSERT, ord, $urandom, 7'sd0);
    send_word(OP_INSERT, shadow_orders[$urandom_range(0, DEPTH - 1)], $urandom, 7'sd0);
    send_word(OP_GET, 16'd0, 32'sd0, 7'(DEPTH - 1));
    send_word(OP_GET, 16'd0, 32'sd0, 7'(DEPTH));
    while (shadow_count > 0)
      send_word(OP_REMOVE, shadow_orders[$urandom_range(0, shadow_count - 1)], 32'sd0,
                7'sd0);
  endtask

  // Hold the result side off for a long stretch while words keep coming,
  // so the block backs up and stalls its request side.
  task automatic test_receiver_holdoff();
    int k;
    sender_gaps_on = 1'b0;
    holdoff_req    = 1'b1;
    for (k = 0; k < 8; k++) begin
      if (k % 2 == 0) send_word(OP_INSERT, 16'(k * 7), $urandom, 7'sd0);
      else send_word(OP_GET, 16'd0, 32'sd0, 7'(k / 2));
    end
    sender_gaps_on = 1'b1;
  endtask

  // Random traffic that swings the table between empty and full, mostly on
  // a small set of hot orders so accumulates, hits and rejects are common.
  task automatic test_random_traffic();
    logic [15:0]        hot_orders [24];
    logic [1:0]         op;
    logic [15:0]        ord;
    logic signed [31:0] val;
    logic signed [6:0]  pos;
    bit                 filling;
    int                 sent;
    int                 r;
    int                 k;
    hot_orders[0] = 16'h0000;
    hot_orders[1] = 16'hFFFF;
    for (k = 2; k < 24; k++) hot_orders[k] = 16'($urandom);
    filling = 1'b1;
    sent    = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent % 100 == 0) begin
        sender_gaps_on     = ($urandom_range(0, 3) != 0);
        receiver_stalls_on = ($urandom_range(0, 3) != 0);
      end
      // Flip direction at the ends, and now and then midway.
      if (shadow_count == DEPTH) filling = 1'b0;
      else if (shadow_count == 0) filling = 1'b1;
      else if ($urandom_range(0, 49) == 0) filling = !filling;

      r = $urandom_range(0, 99);
      if (filling) op = (r < 60) ? OP_INSERT : (r < 75) ? OP_REMOVE :
                        (r < 97) ? OP_GET : OP_UNUSED;
      else op = (r < 25) ? OP_INSERT : (r < 60) ? OP_REMOVE :
                (r < 97) ? OP_GET : OP_UNUSED;

      ord = ($urandom_range(0, 9) < 8) ? hot_orders[$urandom_range(0, 23)] : 16'($urandom);
      if (op == OP_REMOVE && shadow_count > 0 && $urandom_range(0, 9) < 7)
        ord = shadow_orders[$urandom_range(0, shadow_count - 1)];

      r = $urandom_range(0, 99);
      if (r < 10) begin
        case ($urandom_range(0, 3))
          0: val = 32'sh7FFF_FFFF;
          1: val = 32'sh8000_0000;
          2: val = 32'sd0;
          default: val = -32'sd1;
        endcase
      end else begin
        val = $urandom;
        // Cancel an existing coefficient to leave a zero term behind.
        if (r < 25)
          for (k = 0; k < shadow_count; k++)
            if (shadow_orders[k] == ord) val = -shadow_coefs[k];
      end

      r = $urandom_range(0, 99);
      if (r < 70) pos = 7'($urandom_range(0, shadow_count));
      else if (r < 85) pos = 7'($urandom_range(0, 63));
      else pos = 7'(-$urandom_range(1, 64));

      send_word(op, ord, val, pos);
      if (op != OP_UNUSED) sent++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_INSERT;
    in_ch.term_order   = '0;
    in_ch.term_value   = '0;
    in_ch.position     = '0;
    out_ch.ready       = 1'b0;
    shadow_count       = 0;
    error_count        = 0;
    cycle_count        = 0;
    stall_left         = 0;
    holdoff_req        = 1'b0;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    for (int k = 0; k < DEPTH; k++) begin
      shadow_orders[k] = '0;
      shadow_coefs[k]  = '0;
    end

    // Hold reset low, then release it on a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_table();
    test_sorted_insert();
    test_get_positions();
    test_remove_cases();
    test_unused_op();
    test_full_table();
    test_receiver_holdoff();
    test_random_traffic();

    // Drop valid, wait out every prediction, then allow a longest-op margin.
    in_ch.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
